// ===== rtl/core/alt_pkg.sv =====
// Shared types and constants for the address learning table.
// Depends on nothing; used by alt_store and address_learning_table.
`default_nettype none

package alt_pkg;

	localparam int LEN_W      = 12;
	localparam int ADDR_W     = 48;
	localparam int STR_W      = 8;
	localparam int HDR_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int INDEX_W    = 9;
	localparam int COUNT_W    = 10;

	localparam logic [HDR_W-1:0] HEADER_BYTES_RESET = 8'd24;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_SHORT = 2'd0,
		STATUS_KNOWN = 2'd1,
		STATUS_ADDED = 2'd2,
		STATUS_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RESULT
	} state_t;

	// memory port strobes from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/alt_store.sv =====
// Address and strength storage: one write port, one registered read port.
// Depends on alt_pkg.
`default_nettype none

module alt_store #(
	parameter int DEPTH = 512,
	parameter int IDX_W = 9
) (
	input  wire                          clk,
	input  alt_pkg::mem_ctl_t            ctl,
	input  wire  [IDX_W-1:0]             wr_addr,
	input  wire  [alt_pkg::ADDR_W-1:0]   wr_station,
	input  wire  [alt_pkg::STR_W-1:0]    wr_strength,
	input  wire  [IDX_W-1:0]             rd_addr,
	output logic [alt_pkg::ADDR_W-1:0]   rd_data
);

	logic [alt_pkg::ADDR_W-1:0] addr_mem [DEPTH];
	logic [alt_pkg::STR_W-1:0]  strength_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			addr_mem[wr_addr]     <= wr_station;
			strength_mem[wr_addr] <= wr_strength;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= addr_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/address_learning_table.sv =====
// Address learning table top level: sequencer, compare unit, result register.
// Depends on alt_pkg and alt_store.
//
//  channel | signals                                          | dir | handshake
//  --------+--------------------------------------------------+-----+---------------
//  in      | frame_length, station_address, signal_strength   | in  | in_valid/in_ready
//  out     | status, entry_index, entry_count                 | out | out_valid/out_ready
//  cfg     | cfg_data (header_bytes)                          | in  | cfg_we, no wait
//
// A short frame goes from accept straight to the result state. A searched
// frame reads and compares one stored address per cycle through the single
// read port; the read is registered, so each compare follows its read. The
// search ends on a hit or after the last filled entry, and the result state
// then loads the output register. in_ready is high only in idle, in the cycle
// after the load. Reset clears the count and header_bytes to 24; the stores need no
// clearing since only filled entries are read.
// A stalled result holds in the output register; the next frame waits.
`default_nettype none

module address_learning_table #(
	parameter int TABLE_DEPTH = 512
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [alt_pkg::LEN_W-1:0]         frame_length,
	input  wire  [alt_pkg::ADDR_W-1:0]        station_address,
	input  wire  signed [alt_pkg::STR_W-1:0]  signal_strength,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [alt_pkg::STATUS_W-1:0]      status,
	output logic [alt_pkg::INDEX_W-1:0]       entry_index,
	output logic [alt_pkg::COUNT_W-1:0]       entry_count,
	input  wire                               cfg_we,
	input  wire  [alt_pkg::HDR_W-1:0]         cfg_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	alt_pkg::state_t               state_q, state_nxt;
	logic [alt_pkg::HDR_W-1:0]     header_q;
	logic [alt_pkg::ADDR_W-1:0]    addr_q;
	logic [alt_pkg::STR_W-1:0]     strength_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              ptr_q;
	logic                          cmp_vld_s1;
	logic [IDX_W-1:0]              cmp_idx_s1;
	alt_pkg::status_t              res_status_q;
	logic [IDX_W-1:0]              res_idx_q;
	logic                          out_valid_q;
	logic [alt_pkg::STATUS_W-1:0]  status_q;
	logic [alt_pkg::INDEX_W-1:0]   index_q;
	logic [alt_pkg::COUNT_W-1:0]   ecount_q;

	logic [alt_pkg::ADDR_W-1:0]    rd_data;
	alt_pkg::mem_ctl_t             mem_ctl;
	logic                          accept;
	logic                          too_short;
	logic                          more;
	logic                          hit;
	logic                          miss_done;
	logic                          full;
	logic                          load_out;
	logic [31:0]                   idx_wide;
	logic [31:0]                   cnt_wide;

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		in_ready      = 1'b0;
		accept        = 1'b0;
		hit           = 1'b0;
		miss_done     = 1'b0;
		load_out      = 1'b0;
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		too_short     = ({4'd0, header_q} > frame_length);
		more          = (ptr_q < count_q);
		full          = (count_q == DEPTH_CNT);
		case (state_q)
			alt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (in_valid) begin
					state_nxt = too_short ? alt_pkg::ST_RESULT : alt_pkg::ST_SEARCH;
				end
			end
			alt_pkg::ST_SEARCH: begin
				hit           = cmp_vld_s1 && (rd_data == addr_q);
				miss_done     = !cmp_vld_s1 && !more;
				mem_ctl.rd_en = more && !hit;
				mem_ctl.wr_en = miss_done && !full;
				if (hit || miss_done) begin
					state_nxt = alt_pkg::ST_RESULT;
				end
			end
			alt_pkg::ST_RESULT: begin
				load_out = !out_valid_q || out_ready;
				if (load_out) begin
					state_nxt = alt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = alt_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= alt_pkg::HEADER_BYTES_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------
	// search datapath
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= station_address;
			strength_q <= signal_strength;
		end
		cmp_idx_s1 <= ptr_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ptr_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			res_status_q <= alt_pkg::STATUS_SHORT;
			res_idx_q    <= '0;
		end else begin
			cmp_vld_s1 <= mem_ctl.rd_en;
			if (accept) begin
				ptr_q        <= '0;
				res_status_q <= alt_pkg::STATUS_SHORT;
				res_idx_q    <= '0;
			end else if (mem_ctl.rd_en) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (hit) begin
				res_status_q <= alt_pkg::STATUS_KNOWN;
				res_idx_q    <= cmp_idx_s1;
			end else if (miss_done) begin
				if (full) begin
					res_status_q <= alt_pkg::STATUS_FULL;
					res_idx_q    <= '0;
				end else begin
					res_status_q <= alt_pkg::STATUS_ADDED;
					res_idx_q    <= count_q[IDX_W-1:0];
				end
			end
			if (mem_ctl.wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	alt_store #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_store (
		.clk         (clk),
		.ctl         (mem_ctl),
		.wr_addr     (count_q[IDX_W-1:0]),
		.wr_station  (addr_q),
		.wr_strength (strength_q),
		.rd_addr     (ptr_q[IDX_W-1:0]),
		.rd_data     (rd_data)
	);

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	// fit index and count to the output field widths
	always_comb begin
		idx_wide = 32'(res_idx_q);
		cnt_wide = 32'(count_q);
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= res_status_q;
			index_q  <= idx_wide[alt_pkg::INDEX_W-1:0];
			ecount_q <= cnt_wide[alt_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;
	assign entry_count = ecount_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("stored count above table depth");

	a_read_filled: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |-> (ptr_q < count_q))
		else $error("search read beyond filled entries");

	a_count_by_write: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(mem_ctl.wr_en))
		else $error("count changed without an insert");

	a_added_index: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (res_status_q == alt_pkg::STATUS_ADDED))
			|-> (CNT_W'(res_idx_q) + CNT_W'(1) == count_q))
		else $error("added entry is not the last filled entry");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (res_status_q == alt_pkg::STATUS_FULL)) |-> (count_q == DEPTH_CNT))
		else $error("full reported with room left");

endmodule

`default_nettype wire
